@@ rtl/cpst_pkg.sv @@
// Shared constants, codes and control structs for the convex polygon store.
`timescale 1ns / 1ps
`default_nettype none

package cpst_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MIN_VERTICES = 3;
  localparam int COORD_BITS   = 24;

  localparam int OP_W  = 3;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int JW    = $clog2(MAX_VERTICES + 2);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_READ    = 3'd3,
    OP_TEST    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_WALK,
    S_DRAIN,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC
  } cnt_op_t;

  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             turn_en;
    logic             walk_clr;
    logic             commit;
    cnt_op_t          cnt_op;
    logic             out_load;
    logic             out_status;
    logic             out_inside;
    logic             out_vertex;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
    logic             idx_lt_count;
    logic             walk_ok;
    logic             pipe_busy;
    logic             out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/cpst_ctrl.sv @@
// Controller: sequences decode, vertex walks, reads and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module cpst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire cpst_pkg::sts_t sts,
  output cpst_pkg::cmd_t     cmd
);
  import cpst_pkg::*;

  state_t           state_r, state_nxt;
  logic [JW-1:0]    j_r, j_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             pt_mode;
  logic [JW-1:0]    j_last;

  assign pt_mode = (sts.op == OP_TEST);
  assign j_last  = pt_mode ? JW'(n_r) : JW'(n_r) + JW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.cnt_op = CNT_HOLD;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (sts.op)
          OP_CLEAR: begin
            if (!sts.out_busy) begin
              cmd.out_load = 1'b1;
              cmd.cnt_op   = CNT_CLEAR;
              state_nxt    = S_IDLE;
            end
          end
          OP_APPEND: begin
            if (sts.count == CNT_W'(MAX_VERTICES)) begin
              if (!sts.out_busy) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else if (sts.count < CNT_W'(MIN_VERTICES)) begin
              if (!sts.out_busy) begin
                cmd.out_load = 1'b1;
                cmd.commit   = 1'b1;
                cmd.cnt_op   = CNT_INC;
                state_nxt    = S_IDLE;
              end
            end else begin
              n_nxt        = sts.count + CNT_W'(1);
              j_nxt        = '0;
              cmd.walk_clr = 1'b1;
              state_nxt    = S_WALK;
            end
          end
          OP_REPLACE: begin
            if (!sts.idx_lt_count || sts.count < CNT_W'(MIN_VERTICES)) begin
              if (!sts.out_busy) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else if (sts.count == CNT_W'(MIN_VERTICES)) begin
              if (!sts.out_busy) begin
                cmd.out_load = 1'b1;
                cmd.commit   = 1'b1;
                state_nxt    = S_IDLE;
              end
            end else begin
              n_nxt        = sts.count;
              j_nxt        = '0;
              cmd.walk_clr = 1'b1;
              state_nxt    = S_WALK;
            end
          end
          OP_READ: begin
            if (!sts.idx_lt_count) begin
              if (!sts.out_busy) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = sts.idx;
              state_nxt   = S_READ;
            end
          end
          OP_TEST: begin
            if (sts.count < CNT_W'(MIN_VERTICES)) begin
              if (!sts.out_busy) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = 1'b1;
                state_nxt      = S_IDLE;
              end
            end else begin
              n_nxt        = sts.count;
              j_nxt        = '0;
              cmd.walk_clr = 1'b1;
              state_nxt    = S_WALK;
            end
          end
          default: begin
            if (!sts.out_busy) begin
              cmd.out_load   = 1'b1;
              cmd.out_status = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
        endcase
      end

      S_READ: begin
        if (!sts.out_busy) begin
          cmd.out_load   = 1'b1;
          cmd.out_vertex = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_WALK: begin
        cmd.rd_en = 1'b1;
        if (pt_mode) begin
          cmd.turn_en = (j_r != '0);
          cmd.rd_addr = (j_r == j_last) ? '0 : IDX_W'(j_r);
        end else begin
          cmd.turn_en = (j_r >= JW'(2));
          if (j_r == '0)
            cmd.rd_addr = IDX_W'(n_r - CNT_W'(1));
          else if (j_r == j_last)
            cmd.rd_addr = '0;
          else
            cmd.rd_addr = IDX_W'(j_r - JW'(1));
        end
        j_nxt = j_r + JW'(1);
        if (j_r == j_last)
          state_nxt = S_DRAIN;
      end

      S_DRAIN: begin
        if (!sts.pipe_busy)
          state_nxt = S_FINAL;
      end

      S_FINAL: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
          case (sts.op)
            OP_TEST: begin
              cmd.out_inside = 1'b1;
            end
            OP_APPEND: begin
              cmd.out_status = !sts.walk_ok;
              cmd.commit     = sts.walk_ok;
              cmd.cnt_op     = sts.walk_ok ? CNT_INC : CNT_HOLD;
            end
            OP_REPLACE: begin
              cmd.out_status = !sts.walk_ok;
              cmd.commit     = sts.walk_ok;
            end
            default: begin
              cmd.out_status = 1'b1;
            end
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/cpst_dp.sv @@
// Datapath: vertex memory, count, cross-product pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module cpst_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire cpst_pkg::cmd_t                       cmd,
  output cpst_pkg::sts_t                            sts,
  input  wire logic [cpst_pkg::OP_W-1:0]            in_op,
  input  wire logic [cpst_pkg::IDX_W-1:0]           in_index,
  input  wire logic signed [cpst_pkg::COORD_BITS-1:0] in_point_x,
  input  wire logic signed [cpst_pkg::COORD_BITS-1:0] in_point_y,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_status,
  output logic                                      out_inside_res,
  output logic signed [cpst_pkg::COORD_BITS-1:0]    out_vertex_x,
  output logic signed [cpst_pkg::COORD_BITS-1:0]    out_vertex_y,
  output logic [cpst_pkg::CNT_W-1:0]                out_vertex_count
);
  import cpst_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic [OP_W-1:0]  op_r;
  logic [IDX_W-1:0] idx_r;
  logic signed [CW-1:0] px_r, py_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];
  logic signed [CW-1:0] rd_x_r, rd_y_r;
  logic [IDX_W-1:0] rd_addr_q;
  logic rd_valid_q, turn_q;

  logic cand_act;
  logic [IDX_W-1:0] cand_idx;
  logic signed [CW-1:0] dx, dy;

  logic signed [CW-1:0] wa_x_r, wa_y_r, wb_x_r, wb_y_r;
  logic signed [DW-1:0] x1, y1, x2, y2;
  logic signed [DW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic dv_r;
  logic signed [PW-1:0] p_r, q_r;
  logic pv_r;
  logic turn_s;
  logic first_r, sign_r, mismatch_r;

  logic out_valid_r, out_status_r, out_inside_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [CNT_W-1:0] out_count_r;

  assign cand_act = (op_r == OP_APPEND) || (op_r == OP_REPLACE);
  assign cand_idx = (op_r == OP_APPEND) ? IDX_W'(count_r) : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      idx_r <= in_index;
      px_r  <= in_point_x;
      py_r  <= in_point_y;
    end
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_CLEAR: count_nxt = '0;
      CNT_INC:   count_nxt = count_r + CNT_W'(1);
      default:   count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      count_r <= '0;
    else
      count_r <= count_nxt;
  end

  // vertex memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      mem_x[cand_idx] <= px_r;
      mem_y[cand_idx] <= py_r;
    end
    if (cmd.rd_en) begin
      rd_x_r    <= mem_x[cmd.rd_addr];
      rd_y_r    <= mem_y[cmd.rd_addr];
      rd_addr_q <= cmd.rd_addr;
    end
  end

  // the pending corner stands in for the stored one during a check
  assign dx = (cand_act && rd_addr_q == cand_idx) ? px_r : rd_x_r;
  assign dy = (cand_act && rd_addr_q == cand_idx) ? py_r : rd_y_r;

  always_comb begin
    if (op_r == OP_TEST) begin
      x1 = {px_r[CW-1], px_r} - {wb_x_r[CW-1], wb_x_r};
      y1 = {py_r[CW-1], py_r} - {wb_y_r[CW-1], wb_y_r};
      x2 = {dx[CW-1], dx} - {px_r[CW-1], px_r};
      y2 = {dy[CW-1], dy} - {py_r[CW-1], py_r};
    end else begin
      x1 = {wb_x_r[CW-1], wb_x_r} - {wa_x_r[CW-1], wa_x_r};
      y1 = {wb_y_r[CW-1], wb_y_r} - {wa_y_r[CW-1], wa_y_r};
      x2 = {dx[CW-1], dx} - {wb_x_r[CW-1], wb_x_r};
      y2 = {dy[CW-1], dy} - {wb_y_r[CW-1], wb_y_r};
    end
  end

  assign turn_s = (p_r >= q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_q <= 1'b0;
      turn_q     <= 1'b0;
      dv_r       <= 1'b0;
      pv_r       <= 1'b0;
      first_r    <= 1'b1;
      sign_r     <= 1'b0;
      mismatch_r <= 1'b0;
    end else begin
      rd_valid_q <= cmd.rd_en;
      turn_q     <= cmd.rd_en && cmd.turn_en;
      dv_r       <= turn_q;
      pv_r       <= dv_r;
      if (cmd.walk_clr) begin
        first_r    <= 1'b1;
        mismatch_r <= 1'b0;
      end else if (pv_r) begin
        first_r <= 1'b0;
        if (first_r)
          sign_r <= turn_s;
        else if (turn_s != sign_r)
          mismatch_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_q) begin
      wa_x_r <= wb_x_r;
      wa_y_r <= wb_y_r;
      wb_x_r <= dx;
      wb_y_r <= dy;
    end
    if (turn_q) begin
      x1_r <= x1;
      y1_r <= y1;
      x2_r <= x2;
      y2_r <= y2;
    end
    if (dv_r) begin
      p_r <= x1_r * y2_r;
      q_r <= x2_r * y1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_inside_r <= cmd.out_inside && !mismatch_r;
      out_x_r      <= cmd.out_vertex ? rd_x_r : '0;
      out_y_r      <= cmd.out_vertex ? rd_y_r : '0;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_inside_res   = out_inside_r;
  assign out_vertex_x     = out_x_r;
  assign out_vertex_y     = out_y_r;
  assign out_vertex_count = out_count_r;

  assign sts.op           = op_r;
  assign sts.idx          = idx_r;
  assign sts.count        = count_r;
  assign sts.idx_lt_count = ({1'b0, idx_r} < count_r);
  assign sts.walk_ok      = !mismatch_r;
  assign sts.pipe_busy    = rd_valid_q || dv_r || pv_r;
  assign sts.out_busy     = out_valid_r && !out_ready;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten while held");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_commit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> ({1'b0, cand_idx} <= count_r) && (count_r != CNT_W'(MAX_VERTICES)
                   || op_r == OP_REPLACE))
    else $error("corner written outside the polygon");

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cmd.out_vertex) |-> !sts.pipe_busy)
    else $error("result loaded while turns still in flight");

endmodule

`default_nettype wire

@@ rtl/convex_polygon_store_point_test_unit.sv @@
// Clear, fail and below-minimum append/replace answer straight from decode; read goes
// through the registered memory read. Checked append/replace and point test are
// set by the walk over the vertex memory through one cross-product pipeline.
// One item in flight at a time; a finished result waits in the output register.
// Reset (rst_n low, synchronous) empties the polygon; corner storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module convex_polygon_store_point_test_unit (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [cpst_pkg::OP_W-1:0]              in_op,
  input  wire logic [cpst_pkg::IDX_W-1:0]             in_index,
  input  wire logic signed [cpst_pkg::COORD_BITS-1:0] in_point_x,
  input  wire logic signed [cpst_pkg::COORD_BITS-1:0] in_point_y,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        out_status,
  output logic                                        out_inside_res,
  output logic signed [cpst_pkg::COORD_BITS-1:0]      out_vertex_x,
  output logic signed [cpst_pkg::COORD_BITS-1:0]      out_vertex_y,
  output logic [cpst_pkg::CNT_W-1:0]                  out_vertex_count
);
  import cpst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cpst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cpst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_index         (in_index),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_inside_res   (out_inside_res),
    .out_vertex_x     (out_vertex_x),
    .out_vertex_y     (out_vertex_y),
    .out_vertex_count (out_vertex_count)
  );

endmodule

`default_nettype wire
